@@ src/rgrm_pkg.sv @@
`timescale 1ns / 1ps

package rgrm_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int WSIZE_W    = 5;
	localparam int TIME_W     = 32;

	localparam logic CFG_WINDOW_SIZE  = 1'b0;
	localparam logic CFG_MIN_INTERVAL = 1'b1;

	typedef struct packed {
		logic clear;
		logic ins;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic vld;
		logic gt;
	} cell_flags_t;

endpackage

@@ src/rgrm_cell.sv @@
`timescale 1ns / 1ps

module rgrm_cell #(
	parameter int W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rgrm_pkg::cell_ctrl_t    ctrl,
	input  logic signed [W-1:0]     x,
	input  logic signed [W-1:0]     left_val,
	input  rgrm_pkg::cell_flags_t   left_flags,
	input  logic signed [W-1:0]     right_val,
	input  logic                    right_vld,
	output logic signed [W-1:0]     val,
	output rgrm_pkg::cell_flags_t   flags
);
	import rgrm_pkg::*;

	logic signed [W-1:0] val_q;
	logic                vld_q;

	// An empty cell counts as larger than any sample, so the row stays sorted.
	assign val       = val_q;
	assign flags.vld = vld_q;
	assign flags.gt  = !vld_q || (val_q > x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (flags.gt) begin
				vld_q <= vld_q | left_flags.vld;
			end
		end else if (ctrl.shift) begin
			vld_q <= right_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (flags.gt) begin
				val_q <= left_flags.gt ? left_val : x;
			end
		end else if (ctrl.shift) begin
			val_q <= right_val;
		end
	end

endmodule

@@ src/rate_gated_running_median.sv @@
`timescale 1ns / 1ps

// Rate-gated running median over a ring window of signed samples.
// Input channel (in_valid/in_ready) takes a sample and its tick timestamp.
// A sample is stored only if the wrap-around tick distance from the last
// stored one is at least min_interval. Every request yields one result on
// the output channel (out_valid/out_ready): accepted, valid_count and twice
// the median of the valid entries (0 when the window is empty).
// Configuration writes (cfg_valid/cfg_ready, always ready) set window_size
// at index 0 and min_interval at index 1; write them only while idle.
// Each request streams the valid entries of the window into a row of
// sorting cells one entry per cycle, then shifts the row out until the
// middle values have passed. No new request is taken while the sorter
// works; the next one can be taken once the result is registered.
// A new request is taken while an earlier result still waits; if the
// receiver stalls, the next result holds in the sorter until the output
// register frees. Reset empties the window, sets window_size to 16 and
// min_interval to 0; no clearing pass is needed.
module rate_gated_running_median #(
	parameter int MAX_WINDOW  = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [rgrm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic [rgrm_pkg::TIME_W-1:0]          timestamp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 accepted,
	output logic [$clog2(MAX_WINDOW+1)-1:0]      valid_count,
	output logic signed [SAMPLE_BITS:0]          median_twice
);
	import rgrm_pkg::*;

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int MW = SAMPLE_BITS + 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FILL  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_ZERO  = 2'd3;

	logic [WSIZE_W-1:0]          window_size_q;
	logic [TIME_W-1:0]           min_interval_q;
	logic [TIME_W-1:0]           last_time_q;
	logic [PW-1:0]               wp_q;
	logic                        full_q;
	logic [1:0]                  state_q;
	logic [CW-1:0]               k_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               hi_q;
	logic                        acc_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] window_q [MAX_WINDOW];

	logic                        out_valid_q;
	logic                        accepted_q;
	logic [CW-1:0]               count_q;
	logic signed [MW-1:0]        median_q;

	logic [CW-1:0]               size;
	logic [TIME_W-1:0]           diff;
	logic                        acc;
	logic                        wrap_pre;
	logic [PW-1:0]               wp_pre;
	logic                        full_pre;
	logic [CW-1:0]               wp_inc;
	logic [PW-1:0]               wp_new;
	logic                        full_new;
	logic [CW-1:0]               n_new;
	logic                        in_acc;
	logic                        out_free;
	logic                        drain_step;
	logic                        finish;
	logic signed [SAMPLE_BITS-1:0] a_sel;
	logic signed [SAMPLE_BITS-1:0] fill_x;
	cell_ctrl_t                  ctrl;

	logic signed [SAMPLE_BITS-1:0] c_val   [MAX_WINDOW];
	cell_flags_t                   c_flags [MAX_WINDOW];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (window_size_q == '0) begin
			size = CW'(1);
		end else if (window_size_q > MAX_WINDOW) begin
			size = CW'(MAX_WINDOW);
		end else begin
			size = CW'(window_size_q);
		end
		diff     = timestamp - last_time_q;
		acc      = (diff >= min_interval_q);
		wrap_pre = (CW'(wp_q) >= size);
		wp_pre   = wrap_pre ? '0 : wp_q;
		full_pre = full_q | wrap_pre;
		wp_inc   = CW'(wp_pre) + CW'(1);
		if (!acc) begin
			wp_new   = wp_q;
			full_new = full_q;
		end else if (wp_inc >= size) begin
			wp_new   = '0;
			full_new = 1'b1;
		end else begin
			wp_new   = wp_inc[PW-1:0];
			full_new = full_pre;
		end
		if (full_new) begin
			n_new = size;
		end else if (CW'(wp_new) < size) begin
			n_new = CW'(wp_new);
		end else begin
			n_new = size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q  <= WSIZE_W'(16);
			min_interval_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_SIZE:  window_size_q  <= cfg_data[WSIZE_W-1:0];
				CFG_MIN_INTERVAL: min_interval_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			wp_q        <= '0;
			full_q      <= 1'b0;
		end else if (in_acc) begin
			if (acc) begin
				last_time_q <= timestamp;
			end
			wp_q   <= wp_new;
			full_q <= full_new;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && acc) begin
			window_q[wp_pre] <= sample;
		end
	end

	assign fill_x     = window_q[k_q[PW-1:0]];
	assign drain_step = (state_q == S_DRAIN) && ((k_q != hi_q) || out_free);
	assign a_sel      = (lo_q == hi_q) ? c_val[0] : a_q;
	assign finish     = (drain_step && (k_q == hi_q)) || ((state_q == S_ZERO) && out_free);

	always_comb begin
		ctrl.clear = in_acc;
		ctrl.ins   = (state_q == S_FILL);
		ctrl.shift = drain_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						k_q     <= '0;
						state_q <= (n_new == '0) ? S_ZERO : S_FILL;
					end
				end
				S_FILL: begin
					if (k_q == n_q - CW'(1)) begin
						k_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_DRAIN: begin
					if (drain_step) begin
						if (k_q == hi_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + CW'(1);
						end
					end
				end
				S_ZERO: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q   <= n_new;
			lo_q  <= (n_new - CW'(1)) >> 1;
			hi_q  <= n_new >> 1;
			acc_q <= acc;
		end
		if (drain_step && (k_q == lo_q)) begin
			a_q <= c_val[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			accepted_q <= acc_q;
			count_q    <= n_q;
			if (state_q == S_ZERO) begin
				median_q <= '0;
			end else begin
				median_q <= MW'(a_sel) + MW'(c_val[0]);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign valid_count  = count_q;
	assign median_twice = median_q;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] l_val;
		cell_flags_t                   l_flags;
		logic signed [SAMPLE_BITS-1:0] r_val;
		logic                          r_vld;

		if (i == 0) begin : g_first
			assign l_val   = fill_x;
			assign l_flags = '{vld: 1'b1, gt: 1'b0};
		end else begin : g_inner
			assign l_val   = c_val[i-1];
			assign l_flags = c_flags[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_last
			assign r_val = c_val[i];
			assign r_vld = 1'b0;
		end else begin : g_body
			assign r_val = c_val[i+1];
			assign r_vld = c_flags[i+1].vld;
		end

		rgrm_cell #(
			.W(SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.x         (fill_x),
			.left_val  (l_val),
			.left_flags(l_flags),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (c_val[i]),
			.flags     (c_flags[i])
		);
	end

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("sorter did not start after a request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q <= CW'(MAX_WINDOW)))
		else $error("valid count beyond window capacity");

	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> c_flags[0].vld)
		else $error("sort row empty while draining");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(wp_q) < CW'(MAX_WINDOW))
		else $error("write position out of range");

endmodule
